### src/spiee_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI EEPROM command engine package
// Shared types, command codes and size limits for the serial EEPROM model.
// ----------------------------------------------------------------------------
package spiee_pkg;

	// Fixed field and state widths.
	localparam int BYTE_W = 8;
	localparam int ADDR_W = 17;
	localparam int LOG2_W = 5;

	// Memory depth default and the legal range of the size setting.
	localparam int MEM_DEPTH_DEFAULT = 131072;
	localparam logic [LOG2_W-1:0] LOG2_MIN = 5'd9;
	localparam logic [LOG2_W-1:0] LOG2_MAX = 5'd17;

	// Command codes.
	localparam logic [BYTE_W-1:0] CMD_WRSR  = 8'h01;
	localparam logic [BYTE_W-1:0] CMD_WRITE = 8'h02;
	localparam logic [BYTE_W-1:0] CMD_READ  = 8'h03;
	localparam logic [BYTE_W-1:0] CMD_WRDI  = 8'h04;
	localparam logic [BYTE_W-1:0] CMD_RDSR  = 8'h05;
	localparam logic [BYTE_W-1:0] CMD_WREN  = 8'h06;

	// Status register layout.
	localparam logic [BYTE_W-1:0] STATUS_WMASK = 8'h8E;
	localparam int STATUS_WEL_BIT = 1;

	// Fill value of the memory and of the output byte after a data write.
	localparam logic [BYTE_W-1:0] ERASED_BYTE = 8'hFF;

	// Configuration register indexes.
	localparam logic CFG_SIZE_LOG2 = 1'b0;
	localparam logic CFG_PAGE_MASK = 1'b1;

	// Block-protect modes from status bits 3:2.
	typedef enum logic [1:0] {
		PROT_NONE    = 2'd0,
		PROT_QUARTER = 2'd1,
		PROT_HALF    = 2'd2,
		PROT_ALL     = 2'd3
	} prot_mode_t;

	// Where the output byte comes from once a request leaves stage one.
	typedef enum logic [1:0] {
		SRC_KEEP   = 2'd0,
		SRC_STATUS = 2'd1,
		SRC_ERASED = 2'd2,
		SRC_MEM    = 2'd3
	} byte_src_t;

	// One request: a byte from the host and the chip select flag.
	typedef struct packed {
		logic [BYTE_W-1:0] spi_byte;
		logic              keep_selected;
	} spiee_req_t;

	// One result: the byte returned to the host and the dirty flag.
	typedef struct packed {
		logic [BYTE_W-1:0] read_byte;
		logic              save_dirty;
	} spiee_rsp_t;

endpackage

### src/spi_eeprom_command_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI EEPROM command engine
// Serial EEPROM with command decode, status register, block protect and a
// byte-wide synchronous memory, one SPI byte per request.
// ----------------------------------------------------------------------------
// After reset the block first sweeps the memory to 0xFF, one byte a cycle, and
// accepts no request until the sweep is done (configuration writes are taken
// throughout). It then takes one request per cycle unless the output stalls:
// all control state is updated in the accepting cycle and the single memory
// port is read or written there, so requests can follow back to back. The
// result passes through stage one and then the output register: the memory
// read is registered at the accepting edge and the output register follows
// it. A stalled output holds stage one, which in turn holds off new requests.
module spi_eeprom_command_engine_core #(
	parameter int MEM_DEPTH = spiee_pkg::MEM_DEPTH_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  spiee_pkg::spiee_req_t      req,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output spiee_pkg::spiee_rsp_t      rsp,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [spiee_pkg::BYTE_W-1:0] cfg_wdata
);
	import spiee_pkg::*;

	localparam int MEM_AW   = $clog2(MEM_DEPTH);
	localparam int MEM_LOG2 = $clog2(MEM_DEPTH + 1) - 1;

	// Configuration registers.
	logic [LOG2_W-1:0] size_log2_q;
	logic [BYTE_W-1:0] page_mask_q;

	// Control state.
	logic              selected_q;
	logic [BYTE_W-1:0] cmd_q;
	logic [1:0]        phase_q;
	logic [ADDR_W-1:0] addr_q;
	logic [BYTE_W-1:0] status_q;
	logic              dirty_q;

	// Clearing sweep.
	logic              clearing_q;
	logic [MEM_AW-1:0] clr_addr_q;

	// Stage one and output register.
	logic              valid_s1;
	byte_src_t         src_s1;
	logic [BYTE_W-1:0] status_s1;
	logic              dirty_s1;
	logic              rsp_valid_q;
	spiee_rsp_t        rsp_q;

	// Memory.
	logic [BYTE_W-1:0] mem [MEM_DEPTH];
	logic [BYTE_W-1:0] rdata_q;
	logic              mem_we;
	logic              mem_re;
	logic [MEM_AW-1:0] mem_addr;
	logic [BYTE_W-1:0] mem_wdata;

	// Next-state values from the request decode.
	logic              accept;
	logic              s1_adv;
	logic [BYTE_W-1:0] cmd_d;
	logic [1:0]        phase_d;
	logic [ADDR_W-1:0] addr_d;
	logic [BYTE_W-1:0] status_d;
	logic              dirty_d;
	byte_src_t         src_d;
	logic              acc_rd;
	logic              acc_wr;
	logic [ADDR_W-1:0] acc_addr;
	logic [LOG2_W-1:0] eff_log2;
	logic [ADDR_W-1:0] size_mask;
	logic [ADDR_W:0]   size_half;
	logic [ADDR_W:0]   size_q3;

	// Handshake.
	assign s1_adv    = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !clearing_q && (!valid_s1 || s1_adv);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Effective size: clamp the setting and fit it to the memory depth.
	always_comb begin
		eff_log2 = size_log2_q;
		if (eff_log2 < LOG2_MIN) begin
			eff_log2 = LOG2_MIN;
		end
		if (eff_log2 > LOG2_MAX) begin
			eff_log2 = LOG2_MAX;
		end
		if (eff_log2 > LOG2_W'(MEM_LOG2)) begin
			eff_log2 = LOG2_W'(MEM_LOG2);
		end
		size_mask = ~({ADDR_W{1'b1}} << eff_log2);
		size_half = (ADDR_W + 1)'(size_mask) + (ADDR_W + 1)'(1);
		size_half = size_half >> 1;
		size_q3   = size_half + (size_half >> 1);
	end

	// Command decode for the accepted request.
	always_comb begin
		logic [BYTE_W-1:0] v;
		logic [1:0]        ph;
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] a;
		logic [ADDR_W-1:0] a_inc;
		logic [ADDR_W-1:0] pm;
		prot_mode_t        mode;
		logic              blocked;

		v       = req.spi_byte;
		ph      = phase_q;
		base    = addr_q;
		a       = addr_q & size_mask;
		a_inc   = a + ADDR_W'(1);
		pm      = ADDR_W'(page_mask_q);
		mode    = prot_mode_t'(status_q[3:2]);
		blocked = 1'b0;

		cmd_d    = cmd_q;
		phase_d  = phase_q;
		addr_d   = addr_q;
		status_d = status_q;
		dirty_d  = dirty_q;
		src_d    = SRC_KEEP;
		acc_rd   = 1'b0;
		acc_wr   = 1'b0;
		acc_addr = a;

		if (!selected_q) begin
			cmd_d   = v;
			phase_d = 2'd0;
		end else if ((cmd_q == CMD_READ || cmd_q == CMD_WRITE) && phase_q != 2'd3) begin
			// Address collection: restart at the first address byte.
			if (phase_q == 2'd0) begin
				base = '0;
				if (eff_log2 == LOG2_MIN) begin
					ph = 2'd2;
				end else if (eff_log2 == LOG2_MAX) begin
					ph = 2'd0;
				end else begin
					ph = 2'd1;
				end
			end
			case (ph)
				2'd0:    addr_d = {v[0], 16'h0000};
				2'd1:    addr_d = base | {1'b0, v, 8'h00};
				default: addr_d = base | {9'h000, v};
			endcase
			addr_d  = addr_d & size_mask;
			phase_d = (ph == 2'd3) ? ph : ph + 2'd1;
		end else begin
			unique case (cmd_q)
				CMD_WREN: begin
					if (phase_q == 2'd0) begin
						status_d[STATUS_WEL_BIT] = 1'b1;
					end
					phase_d = (phase_q == 2'd3) ? phase_q : phase_q + 2'd1;
				end
				CMD_WRDI: begin
					if (phase_q == 2'd0) begin
						status_d[STATUS_WEL_BIT] = 1'b0;
					end
					phase_d = (phase_q == 2'd3) ? phase_q : phase_q + 2'd1;
				end
				CMD_RDSR: begin
					src_d = SRC_STATUS;
				end
				CMD_WRSR: begin
					if (phase_q == 2'd0 && status_q[STATUS_WEL_BIT]) begin
						status_d = v & STATUS_WMASK;
					end
					phase_d = (phase_q == 2'd3) ? phase_q : phase_q + 2'd1;
				end
				CMD_READ: begin
					src_d  = SRC_MEM;
					acc_rd = 1'b1;
					addr_d = a_inc & size_mask;
				end
				CMD_WRITE: begin
					src_d = SRC_ERASED;
					unique case (mode)
						PROT_QUARTER: blocked = (ADDR_W + 1)'(a) >= size_q3;
						PROT_HALF:    blocked = (ADDR_W + 1)'(a) >= size_half;
						PROT_ALL:     blocked = 1'b1;
						default:      blocked = 1'b0;
					endcase
					if (!blocked) begin
						acc_wr  = 1'b1;
						addr_d  = ((a & ~pm) | (a_inc & pm)) & size_mask;
						dirty_d = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Memory port: the clearing sweep or the accepted request.
	assign mem_we    = clearing_q || (accept && acc_wr);
	assign mem_re    = accept && acc_rd;
	assign mem_addr  = clearing_q ? clr_addr_q : acc_addr[MEM_AW-1:0];
	assign mem_wdata = clearing_q ? ERASED_BYTE : req.spi_byte;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_addr];
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_log2_q <= LOG2_MAX;
			page_mask_q <= 8'hFF;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SIZE_LOG2: size_log2_q <= cfg_wdata[LOG2_W-1:0];
				default:       page_mask_q <= cfg_wdata;
			endcase
		end
	end

	// Clearing sweep after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + MEM_AW'(1);
			if (clr_addr_q == MEM_AW'(MEM_DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Control state update on each accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			selected_q <= 1'b0;
			cmd_q      <= '0;
			phase_q    <= '0;
			addr_q     <= '0;
			status_q   <= '0;
			dirty_q    <= 1'b0;
		end else if (accept) begin
			selected_q <= req.keep_selected;
			cmd_q      <= cmd_d;
			phase_q    <= phase_d;
			addr_q     <= addr_d;
			status_q   <= status_d;
			dirty_q    <= dirty_d;
		end
	end

	// Stage one: waits for the memory read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			src_s1    <= src_d;
			status_s1 <= status_d;
			dirty_s1  <= dirty_d;
		end
	end

	// Output register; the returned byte persists as the output byte state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else if (s1_adv) begin
			rsp_valid_q      <= 1'b1;
			rsp_q.save_dirty <= dirty_s1;
			case (src_s1)
				SRC_STATUS: rsp_q.read_byte <= status_s1;
				SRC_ERASED: rsp_q.read_byte <= ERASED_BYTE;
				SRC_MEM:    rsp_q.read_byte <= rdata_q;
				default:    rsp_q.read_byte <= rsp_q.read_byte;
			endcase
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

`ifndef SYNTH
	// No request is taken while the memory is being cleared.
	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !req_ready)
		else $error("request accepted during clearing sweep");

	// The clearing sweep writes the erased value on every cycle.
	a_clear_writes: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> (mem_we && mem_wdata == ERASED_BYTE && !mem_re))
		else $error("clearing sweep lost its memory write");

	// A stage-one request blocked by a full output stays in stage one.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && rsp_valid_q && !rsp_ready) |=> valid_s1)
		else $error("stage one dropped a request under output stall");

	// The dirty flag never clears once set.
	a_dirty_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		dirty_q |=> dirty_q)
		else $error("dirty flag cleared");
`endif

endmodule
